@@ design/cbse_pkg.sv @@
// Shared types and constants for the column bitplane strip encoder.
// Used by the encoder top level, its port checker and the testbench; depends on nothing.
package cbse_pkg;

	localparam int CFG_W             = 9;
	localparam int PIXEL_W           = 8;
	localparam int PLANE_W           = 8;
	localparam int WORD_W            = 2 * PLANE_W;
	localparam int ROW_W             = 3;
	localparam int DEFAULT_MAX_WIDTH = 256;

	localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(96);
	localparam logic [ROW_W-1:0] ROW_FIRST   = '0;
	localparam logic [ROW_W-1:0] ROW_LAST    = '1;

	// Pixel codes.
	localparam logic [PIXEL_W-1:0] PIX_WHITE = PIXEL_W'(0);
	localparam logic [PIXEL_W-1:0] PIX_DARK  = PIXEL_W'(1);
	localparam logic [PIXEL_W-1:0] PIX_LIGHT = PIXEL_W'(2);
	localparam logic [PIXEL_W-1:0] PIX_BLACK = PIXEL_W'(3);

	// One entry of the per-column store.
	typedef struct packed {
		logic               inv;
		logic [PLANE_W-1:0] light;
		logic [PLANE_W-1:0] dark;
	} col_entry_t;

endpackage

@@ design/column_bitplane_strip_encoder.sv @@
// Column bitplane strip encoder top level: column store, read-modify-write stage
// and output register. Depends on cbse_pkg.

// The block takes one 8-bit pixel per clock in raster order, unless a row-7
// pixel in stage 1 waits on a stalled output register, and for every 8-row
// strip returns one 16-bit word per column when that column's row-7 pixel
// arrives (light plane in the high byte, dark plane in the low byte), with
// tuser flagging a code above 3 anywhere in that column strip and tlast
// marking the last column of the row. Results pass stage 1, then the output
// register. The rate is set by the read-modify-write of the column store,
// whose registered read is covered by a forwarding path when the same column
// is hit on consecutive pixels. The store has no clearing pass: row 0 of each
// strip overwrites the column's entry. image_width may be written only while
// idle; zero acts as one and values above MAX_WIDTH act as MAX_WIDTH.
module column_bitplane_strip_encoder #(
	parameter int MAX_WIDTH = cbse_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cbse_pkg::CFG_W-1:0]   cfg_wdata,      // image_width
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [cbse_pkg::PIXEL_W-1:0] s_axis_tdata,   // [7:0] pixel
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [cbse_pkg::WORD_W-1:0]  m_axis_tdata,   // [15:0] column_word
	output logic                         m_axis_tuser,   // [0] invalid_seen
	output logic                         m_axis_tlast    // strip_last
);
	import cbse_pkg::*;

	localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMPW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

	logic [CFG_W-1:0] width_q;
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_q;

	logic             valid_s1;
	logic [PIXEL_W-1:0] pixel_s1;
	logic [ROW_W-1:0] row_s1;
	logic [CW-1:0]    col_s1;
	logic             last_s1;
	logic             fwd_hit_s1;
	col_entry_t       fwd_entry_s1;
	col_entry_t       rdata_s1;

	logic             out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic             out_inv_q;
	logic             out_last_q;

	col_entry_t       col_mem [MAX_WIDTH];

	logic             accept;
	logic [CMPW-1:0]  width_ext;
	logic [CMPW-1:0]  width_eff;
	logic [CMPW-1:0]  col_inc;
	logic             last_in;
	logic             emit;
	logic             adv_s1;
	col_entry_t       base_entry;
	col_entry_t       new_entry;
	logic [PLANE_W-1:0] row_bit;

	assign accept = s_axis_tvalid && s_axis_tready;

	// Effective width: zero acts as one, saturated at the store depth.
	always_comb begin
		width_ext = CMPW'(width_q);
		if (width_ext == '0) begin
			width_eff = CMPW'(1);
		end else if (width_ext > CMPW'(MAX_WIDTH)) begin
			width_eff = CMPW'(MAX_WIDTH);
		end else begin
			width_eff = width_ext;
		end
		col_inc = CMPW'(col_q) + CMPW'(1);
		last_in = (col_inc >= width_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (cfg_we) begin
			width_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= ROW_FIRST;
			col_q <= '0;
		end else if (accept) begin
			if (last_in) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Read-modify-write of the column entry held in stage 1.
	always_comb begin
		if (row_s1 == ROW_FIRST) begin
			base_entry = '0;
		end else if (fwd_hit_s1) begin
			base_entry = fwd_entry_s1;
		end else begin
			base_entry = rdata_s1;
		end
		row_bit = PLANE_W'(1) << row_s1;
		new_entry = base_entry;
		case (pixel_s1)
			PIX_WHITE: begin
			end
			PIX_DARK: begin
				new_entry.dark = base_entry.dark | row_bit;
			end
			PIX_LIGHT: begin
				new_entry.light = base_entry.light | row_bit;
			end
			PIX_BLACK: begin
				new_entry.dark  = base_entry.dark | row_bit;
				new_entry.light = base_entry.light | row_bit;
			end
			default: begin
				new_entry.inv = 1'b1;
			end
		endcase
	end

	assign emit          = (row_s1 == ROW_LAST);
	assign adv_s1        = valid_s1 && (!emit || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// The store reads old data when written at the same address in the same
	// cycle, so that write is captured alongside the item for forwarding.
	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1     <= s_axis_tdata;
			row_s1       <= row_q;
			col_s1       <= col_q;
			last_s1      <= last_in;
			fwd_hit_s1   <= adv_s1 && (col_s1 == col_q);
			fwd_entry_s1 <= new_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			col_mem[col_s1] <= new_entry;
		end
		if (accept) begin
			rdata_s1 <= col_mem[col_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			out_word_q <= {new_entry.light, new_entry.dark};
			out_inv_q  <= new_entry.inv;
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_word_q;
	assign m_axis_tuser  = out_inv_q;
	assign m_axis_tlast  = out_last_q;

endmodule

@@ design/cbse_checker.sv @@
// Port-level checker for the column bitplane strip encoder, bound to the top
// level. Depends on cbse_pkg.
module cbse_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_we,
	input logic [cbse_pkg::CFG_W-1:0]   cfg_wdata,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [cbse_pkg::WORD_W-1:0]  m_axis_tdata,
	input logic                         m_axis_tuser,
	input logic                         m_axis_tlast
);
	import cbse_pkg::*;

	logic [CFG_W-1:0] width_q;
	logic             in_txn;
	logic             narrow;

	assign in_txn = s_axis_tvalid && s_axis_tready;
	assign narrow = (width_q == CFG_W'(0)) || (width_q == CFG_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (cfg_we) begin
			width_q <= cfg_wdata;
		end
	end

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// With the output register empty, the input side never stalls.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output register");

	// A fresh result rises only after a matching input transaction.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(in_txn, 2))
		else $error("result without matching input transaction");

	// A one-column image makes every column the last one.
	a_narrow_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && narrow |-> m_axis_tlast)
		else $error("tlast missing for single-column image");

endmodule

bind column_bitplane_strip_encoder cbse_checker u_cbse_checker (.*);

@@ dv/column_bitplane_strip_encoder_tb.sv @@
// Self-checking testbench for column_bitplane_strip_encoder: streams pixels with random
// gaps and stalls and predicts every column word in SystemVerilog.
// Depends on cbse_pkg and the encoder top level.
`timescale 1ns / 100ps

module column_bitplane_strip_encoder_tb;
	import cbse_pkg::*;

	localparam int MAX_COLS      = DEFAULT_MAX_WIDTH;
	localparam int RANDOM_ITEMS  = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 4000;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic              inv;
		logic              last;
	} column_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [PIXEL_W-1:0]  s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [WORD_W-1:0]   m_axis_tdata;   // [15:0] column_word
	logic                m_axis_tuser;   // [0] invalid_seen
	logic                m_axis_tlast;   // strip_last

	logic [PIXEL_W-1:0]  pixel_queue[$];
	column_result_t      column_word_queue[$];
	int                  send_idle_pct = 0;
	int                  recv_stall_pct = 0;
	int                  mismatch_count = 0;
	int                  quiet_cycles = 0;

	// Mirror of the encoder state.
	logic [WORD_W-1:0]   col_word_mem[MAX_COLS];
	logic                col_inv_mem[MAX_COLS];
	bit                  col_written[MAX_COLS];
	logic [ROW_W-1:0]    strip_row;
	int                  col_pos;
	logic [CFG_W-1:0]    width_reg;

	column_bitplane_strip_encoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int eff_width(logic [CFG_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_COLS)
			return MAX_COLS;
		return int'(v);
	endfunction

	// Folds one pixel into its column word and queues the column word on row 7.
	task automatic encode_pixel(logic [PIXEL_W-1:0] pix);
		int                w;
		int                c;
		logic [ROW_W-1:0]  r;
		logic              last;
		logic [WORD_W-1:0] word;
		logic              inv;
		column_result_t    res;
		w = eff_width(width_reg);
		r = strip_row;
		c = (col_pos >= MAX_COLS) ? MAX_COLS - 1 : col_pos;
		last = (c + 1 >= w);
		word = (r == ROW_FIRST) ? '0 : col_word_mem[c];
		inv = (r == ROW_FIRST) ? 1'b0 : col_inv_mem[c];
		case (pix)
			PIX_WHITE: ;
			PIX_DARK:  word |= 16'h0001 << r;
			PIX_LIGHT: word |= 16'h0100 << r;
			PIX_BLACK: word |= 16'h0101 << r;
			default:   inv = 1'b1;
		endcase
		col_word_mem[c] = word;
		col_inv_mem[c] = inv;
		col_written[c] = 1'b1;
		if (r == ROW_LAST) begin
			res.word = word;
			res.inv = inv;
			res.last = last;
			column_word_queue.push_back(res);
		end
		if (last) begin
			col_pos = 0;
			strip_row = r + 1'b1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	// A width may grow mid-strip only if every column it covers already holds data.
	function automatic bit width_ok(logic [CFG_W-1:0] v);
		int w;
		w = eff_width(v);
		if (strip_row == ROW_FIRST)
			return 1'b1;
		for (int i = 0; i < w; i++)
			if (!col_written[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic int strip_remaining();
		int w;
		int first;
		w = eff_width(width_reg);
		if (strip_row == ROW_FIRST && col_pos == 0)
			return 0;
		first = (col_pos >= w) ? 1 : w - col_pos;
		return first + (int'(ROW_LAST) - int'(strip_row)) * w;
	endfunction

	function automatic logic [CFG_W-1:0] pick_width();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return CFG_W'($urandom_range(1, 8));
		if (r < 85)
			return CFG_W'($urandom_range(9, 32));
		if (r < 92)
			return CFG_W'($urandom_range(33, 96));
		if (r < 96)
			return '0;
		return CFG_W'($urandom_range(256, 511));
	endfunction

	task automatic push_random(int count, int bad_pct);
		logic [PIXEL_W-1:0] p;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < bad_pct)
				p = PIXEL_W'($urandom_range(255));
			else
				p = PIXEL_W'($urandom_range(3));
			pixel_queue.push_back(p);
		end
	endtask

	// Returns once every pixel is taken, every column word has come back and the
	// pipeline has had time to empty.
	task automatic wait_idle();
		while (pixel_queue.size() != 0 || s_axis_tvalid || column_word_queue.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_width(logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pixel_queue.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : monitor_proc
		column_result_t due;
		if (!arst_n) begin
			strip_row = ROW_FIRST;
			col_pos = 0;
			width_reg = WIDTH_RESET;
			foreach (col_written[i])
				col_written[i] = 1'b0;
		end else begin
			if (cfg_we)
				width_reg = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				encode_pixel(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (column_word_queue.size() == 0) begin
					$error("column word %h arrived with none pending", m_axis_tdata);
					mismatch_count++;
				end else begin
					due = column_word_queue.pop_front();
					if (m_axis_tdata !== due.word) begin
						$error("column_word: expected %h, got %h", due.word, m_axis_tdata);
						mismatch_count++;
					end
					if (m_axis_tuser !== due.inv) begin
						$error("invalid_seen: expected %b, got %b", due.inv, m_axis_tuser);
						mismatch_count++;
					end
					if (m_axis_tlast !== due.last) begin
						$error("strip_last: expected %b, got %b", due.last, m_axis_tlast);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Ends a run that stops making progress.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int               random_count;
		int               n;
		logic [CFG_W-1:0] cand;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 24;
		recv_stall_pct = 63;

		// Width zero behaves as one column, so every eighth pixel closes a strip.
		set_width('0);
		pixel_queue = '{PIX_WHITE, PIX_DARK, PIX_LIGHT, PIX_BLACK, 8'd4, 8'hFF, PIX_BLACK,
			PIX_LIGHT};
		// A fresh strip must overwrite the previous word and invalid flag.
		repeat (8) pixel_queue.push_back(PIX_BLACK);
		pixel_queue.push_back(8'h80);
		repeat (6) pixel_queue.push_back(PIX_DARK);
		pixel_queue.push_back(8'h7F);
		wait_idle();

		// Shrink the row while the column index is already past the new width.
		set_width(CFG_W'(20));
		push_random(50, 10);
		wait_idle();
		set_width(CFG_W'(5));
		push_random(strip_remaining(), 10);
		wait_idle();

		// Fill all columns on row 0, narrow for the middle rows, then finish row 7
		// with a width that saturates to the full store.
		set_width(CFG_W'(MAX_COLS));
		push_random(MAX_COLS, 10);
		wait_idle();
		set_width(CFG_W'(3));
		push_random(18, 10);
		wait_idle();
		set_width('1);
		push_random(MAX_COLS, 10);
		wait_idle();

		random_count = 0;
		while (random_count < RANDOM_ITEMS) begin
			case (random_count * 3 / RANDOM_ITEMS)
				0: begin
					send_idle_pct = 24;
					recv_stall_pct = 63;
				end
				1: begin
					send_idle_pct = 63;
					recv_stall_pct = 24;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			n = strip_remaining();
			if ($urandom_range(3) == 0 && n <= 200) begin
				push_random(n, 10);
				random_count += n;
				wait_idle();
			end
			cand = pick_width();
			if (!width_ok(cand))
				cand = CFG_W'(eff_width(width_reg));
			set_width(cand);
			n = $urandom_range(8, 90);
			push_random(n, 12);
			random_count += n;
			wait_idle();
		end

		if (mismatch_count == 0 && column_word_queue.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ column_bitplane_strip_encoder.f @@
design/cbse_pkg.sv
design/column_bitplane_strip_encoder.sv
design/cbse_checker.sv
dv/column_bitplane_strip_encoder_tb.sv
